// File: rtl/fsd_pkg.sv
// Shared types, constants and arithmetic helpers of the palette dither block.
package fsd_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int PAL_N     = 256;
    localparam int ERR_W     = 11;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int PAL_AW    = $clog2(PAL_N);
    localparam int ERR_DEPTH = 2 * MAX_WIDTH;
    localparam int ERR_AW    = $clog2(ERR_DEPTH);
    localparam int CELL_W    = 3 * ERR_W;
    localparam int RGB_W     = 24;
    localparam int CFG_W     = 16;
    localparam int CFG_AW    = 2;

    localparam logic [1:0] MODE_PIXEL    = 2'd0;
    localparam logic [1:0] MODE_LOAD_OLD = 2'd1;
    localparam logic [1:0] MODE_LOAD_NEW = 2'd2;
    localparam logic [1:0] MODE_NOP      = 2'd3;

    localparam logic [CFG_AW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_OLD_SIZE     = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_NEW_SIZE     = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } fsd_in_t;

    typedef struct packed {
        logic [7:0] new_index;
        logic       last_of_frame;
    } fsd_out_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } fsd_rgb_t;

    typedef struct packed {
        logic              start;
        logic              valid;
        logic [PAL_AW-1:0] idx;
    } fsd_cand_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SRC,
        ST_ADJ,
        ST_SCAN,
        ST_WAIT,
        ST_TAP_RD,
        ST_TAP_WR,
        ST_DONE
    } fsd_state_t;

    // Source colour plus carried error, clamped to 0..255.
    function automatic logic [7:0] clamp_byte(input logic [7:0] base,
                                              input logic signed [ERR_W-1:0] err);
        logic signed [ERR_W:0] s;
        s = $signed({{(ERR_W+1-8){1'b0}}, base}) + $signed({err[ERR_W-1], err});
        if (s[ERR_W]) begin
            return 8'd0;
        end else if (s[ERR_W-1:8] != '0) begin
            return 8'd255;
        end
        return s[7:0];
    endfunction

    // One diffusion term: (e*wt+8) >>> 4.
    function automatic logic signed [7:0] spread(input logic signed [8:0] e,
                                                 input logic [2:0] wt);
        logic signed [12:0] p;
        p = $signed({{4{e[8]}}, e}) * $signed({10'd0, wt}) + 13'sd8;
        return $signed(p[11:4]);
    endfunction

    // Stored error plus a term, saturated to the cell width.
    function automatic logic signed [ERR_W-1:0] sat_add(input logic signed [ERR_W-1:0] acc,
                                                        input logic signed [7:0] d);
        logic signed [ERR_W:0] s;
        s = $signed({acc[ERR_W-1], acc}) + $signed({{(ERR_W-7){d[7]}}, d});
        if (s[ERR_W] != s[ERR_W-1]) begin
            return s[ERR_W] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
        end
        return s[ERR_W-1:0];
    endfunction

endpackage

// File: rtl/fsd_ram.sv
// Generic simple dual-port RAM with registered read.
module fsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/fsd_nearest.sv
// Nearest-colour unit: squared RGB distance per candidate and running minimum.
module fsd_nearest (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  fsd_pkg::fsd_cand_t        cand,
    input  fsd_pkg::fsd_rgb_t         cand_rgb,
    input  fsd_pkg::fsd_rgb_t         pix_rgb,
    output logic [fsd_pkg::PAL_AW-1:0] best_idx,
    output fsd_pkg::fsd_rgb_t         best_rgb
);
    import fsd_pkg::*;

    logic signed [8:0]  t_r, t_g, t_b;
    logic signed [17:0] p_r, p_g, p_b;
    logic [15:0]        sq_r_reg, sq_g_reg, sq_b_reg;
    logic               s1_v_reg;
    logic [PAL_AW-1:0]  s1_idx_reg;
    fsd_rgb_t           s1_rgb_reg;
    logic [17:0]        dist_sum;
    logic [17:0]        best_d_reg;
    logic [PAL_AW-1:0]  best_idx_reg;
    fsd_rgb_t           best_rgb_reg;

    assign t_r = $signed({1'b0, pix_rgb.r}) - $signed({1'b0, cand_rgb.r});
    assign t_g = $signed({1'b0, pix_rgb.g}) - $signed({1'b0, cand_rgb.g});
    assign t_b = $signed({1'b0, pix_rgb.b}) - $signed({1'b0, cand_rgb.b});
    assign p_r = t_r * t_r;
    assign p_g = t_g * t_g;
    assign p_b = t_b * t_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else begin
            s1_v_reg <= cand.valid;
        end
    end

    always_ff @(posedge aclk) begin
        sq_r_reg   <= p_r[15:0];
        sq_g_reg   <= p_g[15:0];
        sq_b_reg   <= p_b[15:0];
        s1_idx_reg <= cand.idx;
        s1_rgb_reg <= cand_rgb;
    end

    assign dist_sum = 18'(sq_r_reg) + 18'(sq_g_reg) + 18'(sq_b_reg);

    // Strict compare in ascending order keeps the lowest index on a tie.
    always_ff @(posedge aclk) begin
        if (cand.start) begin
            best_d_reg   <= '1;
            best_idx_reg <= '0;
        end else if (s1_v_reg && (dist_sum < best_d_reg)) begin
            best_d_reg   <= dist_sum;
            best_idx_reg <= s1_idx_reg;
            best_rgb_reg <= s1_rgb_reg;
        end
    end

    assign best_idx = best_idx_reg;
    assign best_rgb = best_rgb_reg;

endmodule

// File: rtl/floyd_steinberg_palette_dither_top.sv
// Top level of the Floyd-Steinberg palette remapper: sequencer, memories, error update.
//
// Remaps an indexed raster image from a source palette to a target palette with
// Floyd-Steinberg error diffusion. Load items (mode 1 and 2) write one palette entry;
// mode 3 is dropped. For a pixel item, one target entry is read from the target
// palette memory and compared per cycle, then each of the four neighbor error cells
// that lies inside the row is updated by a read-modify-write in the single error
// memory. A pixel that ends a row is followed by a sweep that zeroes all 1024
// cells of the finished error row; a pixel that ends a frame, and reset, are
// followed by a sweep over all 2048 cells of both rows.
// During any sweep s_ready stays low while configuration writes are still taken.
// The result transfer sits in an output register, so a stalled m_ready only holds
// the block at the end of the next pixel. Palette entries read before being loaded
// return unspecified colours.
module floyd_steinberg_palette_dither_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  fsd_pkg::fsd_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output fsd_pkg::fsd_out_t               m_data,
    input  logic                            cfg_we,
    input  logic [fsd_pkg::CFG_AW-1:0]      cfg_addr,
    input  logic [fsd_pkg::CFG_W-1:0]       cfg_wdata
);
    import fsd_pkg::*;

    localparam logic [1:0] TAP_RIGHT       = 2'd0;
    localparam logic [1:0] TAP_BELOW_RIGHT = 2'd1;
    localparam logic [1:0] TAP_BELOW_LEFT  = 2'd2;
    localparam logic [1:0] TAP_BELOW       = 2'd3;

    fsd_state_t state_reg, state_next;

    // Configuration registers.
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [8:0]  old_size_reg;
    logic [8:0]  new_size_reg;

    // Raster position.
    logic [COL_W-1:0] col_reg;
    logic [15:0]      row_reg;
    logic             sel_reg;

    // Per-pixel working state.
    logic [PAL_AW-1:0] pix_idx_reg;
    logic              src_ok_reg;
    fsd_rgb_t          adj_reg;
    logic [PAL_AW-1:0] k_reg;
    logic              wait_reg;
    logic [1:0]        tap_reg;
    logic              cand_v_reg;
    logic [PAL_AW-1:0] cand_k_reg;
    logic [ERR_AW-1:0] clr_addr_reg, clr_last_reg;

    logic     m_valid_reg;
    fsd_out_t m_data_reg;

    // Derived limits.
    logic [10:0]       w_eff;
    logic [15:0]       h_eff;
    logic [8:0]        n_eff;
    logic [PAL_AW-1:0] n_last;
    logic              has_right, has_left, row_end, frame_end;

    // Memory ports.
    logic [RGB_W-1:0]  src_rdata, tgt_rdata;
    logic              src_we, tgt_we;
    logic [PAL_AW-1:0] src_raddr, tgt_raddr;
    logic [CELL_W-1:0] err_rdata, err_wdata;
    logic              err_we;
    logic [ERR_AW-1:0] err_raddr, err_waddr;

    // Sequencer outputs.
    logic      accept, pixel_accept, out_free, scan_issue;
    fsd_cand_t cand;
    logic [PAL_AW-1:0] best_idx;
    fsd_rgb_t          best_rgb;

    // Tap selection and error arithmetic.
    logic              tap_ok;
    logic [ERR_AW-1:0] tap_addr;
    logic [2:0]        tap_wt;
    logic signed [8:0] e_r, e_g, e_b;
    logic signed [ERR_W-1:0] cell_r, cell_g, cell_b;
    fsd_rgb_t          src_rgb, adj_next;

    assign accept       = s_valid && s_ready;
    assign pixel_accept = accept && (s_data.mode == MODE_PIXEL);
    assign out_free     = !m_valid_reg || m_ready;

    // Effective limits: zero reads as one, oversize saturates.
    always_comb begin
        priority if (width_reg == '0) begin
            w_eff = 11'd1;
        end else if (width_reg > 11'(MAX_WIDTH)) begin
            w_eff = 11'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        h_eff = (height_reg == '0) ? 16'd1 : height_reg;
        priority if (new_size_reg == '0) begin
            n_eff = 9'd1;
        end else if (new_size_reg > 9'(PAL_N)) begin
            n_eff = 9'(PAL_N);
        end else begin
            n_eff = new_size_reg;
        end
    end

    assign n_last    = PAL_AW'(n_eff - 9'd1);
    assign has_right = (11'(col_reg) + 11'd1) < w_eff;
    assign has_left  = (col_reg != '0);
    assign row_end   = !has_right;
    assign frame_end = row_end && ((17'(row_reg) + 17'd1) >= 17'(h_eff));

    // Neighbor cells: right in the current row, three below in the next row.
    always_comb begin
        unique case (tap_reg)
            TAP_RIGHT: begin
                tap_ok   = has_right;
                tap_addr = {sel_reg, col_reg + COL_W'(1)};
                tap_wt   = 3'd7;
            end
            TAP_BELOW_RIGHT: begin
                tap_ok   = has_right;
                tap_addr = {~sel_reg, col_reg + COL_W'(1)};
                tap_wt   = 3'd1;
            end
            TAP_BELOW_LEFT: begin
                tap_ok   = has_left;
                tap_addr = {~sel_reg, col_reg - COL_W'(1)};
                tap_wt   = 3'd3;
            end
            default: begin
                tap_ok   = 1'b1;
                tap_addr = {~sel_reg, col_reg};
                tap_wt   = 3'd5;
            end
        endcase
    end

    // Quantization error per channel: clamped colour minus chosen colour.
    assign e_r = $signed({1'b0, adj_reg.r}) - $signed({1'b0, best_rgb.r});
    assign e_g = $signed({1'b0, adj_reg.g}) - $signed({1'b0, best_rgb.g});
    assign e_b = $signed({1'b0, adj_reg.b}) - $signed({1'b0, best_rgb.b});

    assign cell_r = $signed(err_rdata[CELL_W-1 -: ERR_W]);
    assign cell_g = $signed(err_rdata[2*ERR_W-1 -: ERR_W]);
    assign cell_b = $signed(err_rdata[ERR_W-1:0]);

    // Source colour, black when the index is beyond the old palette size.
    assign src_rgb  = src_ok_reg ? fsd_rgb_t'(src_rdata) : '0;
    assign adj_next = '{r: clamp_byte(src_rgb.r, cell_r),
                        g: clamp_byte(src_rgb.g, cell_g),
                        b: clamp_byte(src_rgb.b, cell_b)};

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == clr_last_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (pixel_accept) begin
                    state_next = ST_SRC;
                end
            end
            ST_SRC:  state_next = ST_ADJ;
            ST_ADJ:  state_next = ST_SCAN;
            ST_SCAN: begin
                if (k_reg == n_last) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (wait_reg) begin
                    state_next = ST_TAP_RD;
                end
            end
            ST_TAP_RD: begin
                if (tap_ok) begin
                    state_next = ST_TAP_WR;
                end else if (tap_reg == TAP_BELOW) begin
                    state_next = ST_DONE;
                end
            end
            ST_TAP_WR: begin
                state_next = (tap_reg == TAP_BELOW) ? ST_DONE : ST_TAP_RD;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = row_end ? ST_CLEAR : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: memory ports and handshake.
    always_comb begin
        s_ready    = 1'b0;
        src_raddr  = pix_idx_reg;
        tgt_raddr  = k_reg;
        err_raddr  = tap_addr;
        err_we     = 1'b0;
        err_waddr  = tap_addr;
        err_wdata  = {sat_add(cell_r, spread(e_r, tap_wt)),
                      sat_add(cell_g, spread(e_g, tap_wt)),
                      sat_add(cell_b, spread(e_b, tap_wt))};
        scan_issue = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                err_we    = 1'b1;
                err_waddr = clr_addr_reg;
                err_wdata = '0;
            end
            ST_IDLE: s_ready = 1'b1;
            ST_SRC:  err_raddr = {sel_reg, col_reg};
            ST_SCAN: scan_issue = 1'b1;
            ST_TAP_WR: err_we = 1'b1;
            default: begin
            end
        endcase
    end

    assign src_we = accept && (s_data.mode == MODE_LOAD_OLD);
    assign tgt_we = accept && (s_data.mode == MODE_LOAD_NEW);

    assign cand = '{start: (state_reg == ST_ADJ), valid: cand_v_reg, idx: cand_k_reg};

    fsd_ram #(.WIDTH(RGB_W), .DEPTH(PAL_N)) u_src_pal (
        .aclk  (aclk),
        .we    (src_we),
        .waddr (s_data.index),
        .wdata ({s_data.red, s_data.green, s_data.blue}),
        .raddr (src_raddr),
        .rdata (src_rdata)
    );

    fsd_ram #(.WIDTH(RGB_W), .DEPTH(PAL_N)) u_tgt_pal (
        .aclk  (aclk),
        .we    (tgt_we),
        .waddr (s_data.index),
        .wdata ({s_data.red, s_data.green, s_data.blue}),
        .raddr (tgt_raddr),
        .rdata (tgt_rdata)
    );

    fsd_ram #(.WIDTH(CELL_W), .DEPTH(ERR_DEPTH)) u_err_rows (
        .aclk  (aclk),
        .we    (err_we),
        .waddr (err_waddr),
        .wdata (err_wdata),
        .raddr (err_raddr),
        .rdata (err_rdata)
    );

    fsd_nearest u_nearest (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cand     (cand),
        .cand_rgb (fsd_rgb_t'(tgt_rdata)),
        .pix_rgb  (adj_reg),
        .best_idx (best_idx),
        .best_rgb (best_rgb)
    );

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            width_reg    <= 11'd1;
            height_reg   <= 16'd1;
            old_size_reg <= 9'd256;
            new_size_reg <= 9'd256;
            col_reg      <= '0;
            row_reg      <= '0;
            sel_reg      <= 1'b0;
            clr_addr_reg <= '0;
            clr_last_reg <= '1;
            k_reg        <= '0;
            wait_reg     <= 1'b0;
            tap_reg      <= TAP_RIGHT;
            cand_v_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cand_v_reg <= scan_issue;

            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_IMAGE_WIDTH:  width_reg    <= cfg_wdata[10:0];
                    CFG_IMAGE_HEIGHT: height_reg   <= cfg_wdata[15:0];
                    CFG_OLD_SIZE:     old_size_reg <= cfg_wdata[8:0];
                    default:          new_size_reg <= cfg_wdata[8:0];
                endcase
            end

            // Sweep the error memory one cell per cycle.
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + ERR_AW'(1);
            end

            if (state_reg == ST_ADJ) begin
                k_reg <= '0;
            end else if (scan_issue) begin
                k_reg <= k_reg + PAL_AW'(1);
            end

            if (state_reg == ST_SCAN) begin
                wait_reg <= 1'b0;
                tap_reg  <= TAP_RIGHT;
            end else if (state_reg == ST_WAIT) begin
                wait_reg <= 1'b1;
            end

            // Advance to the next tap after a write or a skipped tap.
            if ((state_reg == ST_TAP_WR) || ((state_reg == ST_TAP_RD) && !tap_ok)) begin
                tap_reg <= tap_reg + 2'd1;
            end

            // Raise the result on pixel completion, drop it after its transfer.
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // Finish the pixel: advance the raster position.
            if ((state_reg == ST_DONE) && out_free) begin
                if (frame_end) begin
                    col_reg      <= '0;
                    row_reg      <= '0;
                    sel_reg      <= 1'b0;
                    clr_addr_reg <= '0;
                    clr_last_reg <= '1;
                end else if (row_end) begin
                    col_reg      <= '0;
                    row_reg      <= row_reg + 16'd1;
                    sel_reg      <= ~sel_reg;
                    clr_addr_reg <= {sel_reg, {COL_W{1'b0}}};
                    clr_last_reg <= {sel_reg, {COL_W{1'b1}}};
                end else begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (pixel_accept) begin
            pix_idx_reg <= s_data.index;
            src_ok_reg  <= (9'(s_data.index) < old_size_reg);
        end
        if (state_reg == ST_ADJ) begin
            adj_reg <= adj_next;
        end
        cand_k_reg <= k_reg;
        if ((state_reg == ST_DONE) && out_free) begin
            m_data_reg <= '{new_index: best_idx, last_of_frame: frame_end};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A pixel transfer keeps the block busy on the following cycle.
    a_pixel_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        pixel_accept |=> !s_ready)
        else $error("block ready right after a pixel transfer");

    // A new result only appears when a pixel completes.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside pixel completion");

    // A frame-end result leaves the raster position at the origin.
    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) && m_data.last_of_frame |-> (col_reg == '0) && (row_reg == '0)
            && !sel_reg)
        else $error("raster position not reset at frame end");

endmodule

// File: sim/floyd_steinberg_palette_dither_top_tb.sv
// Self-checking testbench for the Floyd-Steinberg palette remapper.
module floyd_steinberg_palette_dither_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fsd_pkg::*;

    // Cycles without any transfer before the run is declared hung. Covers a
    // full two-row clearing sweep, a 256-entry scan, the receiver hold-off
    // and the settle pause before configuration writes, several times over.
    localparam int HANG_LIMIT   = 20000;
    // Settle time after the last result before touching configuration.
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AT_RESULT = 60;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    fsd_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    fsd_out_t m_data;
    logic              cfg_we = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    always #2 aclk = ~aclk;

    floyd_steinberg_palette_dither_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the remapper: palettes, error rows, raster position
    // ------------------------------------------------------------------
    logic [23:0] src_pal [PAL_N];
    logic [23:0] tgt_pal [PAL_N];
    int          err_row [2][MAX_WIDTH][3];
    int unsigned img_w = 1, img_h = 1, old_sz = 256, new_sz = 256;
    int unsigned col_cnt = 0, row_cnt = 0;
    bit          row_sel = 1'b0;

    // Remapped indexes waiting for their transfer, oldest first.
    fsd_out_t    remap_queue [$];

    int unsigned mismatches = 0;
    int unsigned pixels_sent = 0, loads_sent = 0, drops_sent = 0, results_seen = 0;
    int unsigned frames_seen = 0;
    bit          no_idle = 1'b0;

    function automatic int chan(logic [23:0] p, int c);
        return (p >> (16 - 8 * c)) & 255;
    endfunction

    // Add one diffusion term to a stored error, saturating to the cell width.
    function automatic int sat_err(int acc, int delta);
        int s;
        s = acc + delta;
        if (s > 1023) s = 1023;
        if (s < -1024) s = -1024;
        return s;
    endfunction

    // Advance the shadow state by one item; return a result for a pixel.
    task automatic remap_item(input fsd_in_t it, output bit made, output fsd_out_t res);
        int unsigned w, h, n, x, best, best_d, d;
        int          cur, nxt, adj[3], e[3], base, t;
        bit          row_end, frame_end;
        made = 1'b0;
        res  = '0;
        case (it.mode)
            MODE_LOAD_OLD: src_pal[it.index] = {it.red, it.green, it.blue};
            MODE_LOAD_NEW: tgt_pal[it.index] = {it.red, it.green, it.blue};
            MODE_PIXEL: begin
                w = (img_w == 0) ? 1 : img_w;
                if (w > MAX_WIDTH) w = MAX_WIDTH;
                h = (img_h == 0) ? 1 : img_h;
                n = (new_sz == 0) ? 1 : new_sz;
                if (n > PAL_N) n = PAL_N;
                x = col_cnt % MAX_WIDTH;
                cur = row_sel;
                nxt = !row_sel;
                for (int c = 0; c < 3; c++) begin
                    base = (it.index < old_sz) ? chan(src_pal[it.index], c) : 0;
                    t = base + err_row[cur][x][c];
                    adj[c] = (t < 0) ? 0 : ((t > 255) ? 255 : t);
                end
                best = 0;
                best_d = 32'hFFFF_FFFF;
                for (int k = 0; k < n; k++) begin
                    d = 0;
                    for (int c = 0; c < 3; c++) begin
                        t = adj[c] - chan(tgt_pal[k], c);
                        d += t * t;
                    end
                    if (d < best_d) begin
                        best_d = d;
                        best = k;
                    end
                end
                // Spread with 7/16 right, 3/16 down-left, 5/16 down, 1/16 down-right.
                for (int c = 0; c < 3; c++) begin
                    e[c] = adj[c] - chan(tgt_pal[best], c);
                    if (x + 1 < w) begin
                        err_row[cur][x+1][c] = sat_err(err_row[cur][x+1][c], (e[c]*7 + 8) >>> 4);
                        err_row[nxt][x+1][c] = sat_err(err_row[nxt][x+1][c], (e[c] + 8) >>> 4);
                    end
                    if (x > 0)
                        err_row[nxt][x-1][c] = sat_err(err_row[nxt][x-1][c], (e[c]*3 + 8) >>> 4);
                    err_row[nxt][x][c] = sat_err(err_row[nxt][x][c], (e[c]*5 + 8) >>> 4);
                end
                row_end = (x + 1 >= w);
                frame_end = row_end && (row_cnt + 1 >= h);
                if (frame_end) begin
                    for (int r = 0; r < 2; r++)
                        for (int i = 0; i < MAX_WIDTH; i++)
                            for (int c = 0; c < 3; c++) err_row[r][i][c] = 0;
                    col_cnt = 0;
                    row_cnt = 0;
                    row_sel = 1'b0;
                end else if (row_end) begin
                    for (int i = 0; i < MAX_WIDTH; i++)
                        for (int c = 0; c < 3; c++) err_row[cur][i][c] = 0;
                    col_cnt = 0;
                    row_cnt = (row_cnt + 1) & 16'hFFFF;
                    row_sel = nxt;
                end else begin
                    col_cnt = x + 1;
                end
                res.new_index = best[7:0];
                res.last_of_frame = frame_end;
                made = 1'b1;
            end
            default: ;  // mode 3 is dropped
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Offer one item, hold it until the transfer, then maybe idle a while.
    task automatic send_item(input fsd_in_t it);
        bit       made;
        fsd_out_t res;
        int       gap;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        remap_item(it, made, res);
        if (made) remap_queue.push_back(res);
        case (it.mode)
            MODE_PIXEL:    pixels_sent++;
            MODE_LOAD_OLD,
            MODE_LOAD_NEW: loads_sent++;
            default:       drops_sent++;
        endcase
        gap = (!no_idle && $urandom_range(0, 99) < 33) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Lower valid, wait for every result, then let the block settle.
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (remap_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_AW-1:0] addr, input int unsigned val);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val[CFG_W-1:0];
        @(posedge aclk);
        case (addr)
            CFG_IMAGE_WIDTH:  img_w  = val & 11'h7FF;
            CFG_IMAGE_HEIGHT: img_h  = val & 16'hFFFF;
            CFG_OLD_SIZE:     old_sz = val & 9'h1FF;
            default:          new_sz = val & 9'h1FF;
        endcase
    endtask

    task automatic set_config(input int unsigned w, h, o, n);
        cfg_write(CFG_IMAGE_WIDTH, w);
        cfg_write(CFG_IMAGE_HEIGHT, h);
        cfg_write(CFG_OLD_SIZE, o);
        cfg_write(CFG_NEW_SIZE, n);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic fsd_in_t mk(logic [1:0] m, logic [7:0] i, logic [23:0] rgb);
        fsd_in_t it;
        it.mode  = m;
        it.index = i;
        {it.red, it.green, it.blue} = rgb;
        return it;
    endfunction

    // Directed rows. With a one-pixel frame and a black/white target the
    // answers are obvious; error is wiped after every pixel.
    typedef struct {
        fsd_in_t  item;
        bit       known;
        fsd_out_t want;
    } dir_row_t;

    dir_row_t dir_rows [$];

    // Random phases: geometry, palette sizes, item count, burst mode.
    typedef struct {
        int unsigned w, h, o, n, cnt;
        bit          burst;
    } phase_t;

    phase_t phases [$];

    initial begin
        fsd_in_t  it;
        fsd_out_t res;
        int       r;

        for (int i = 0; i < PAL_N; i++) begin
            src_pal[i] = '0;
            tgt_pal[i] = '0;
        end
        for (int rr = 0; rr < 2; rr++)
            for (int i = 0; i < MAX_WIDTH; i++)
                for (int c = 0; c < 3; c++) err_row[rr][i][c] = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Load every palette entry so no unloaded entry is ever read.
        for (int i = 0; i < PAL_N; i++) begin
            send_item(mk(MODE_LOAD_OLD, i[7:0], 24'($urandom())));
            send_item(mk(MODE_LOAD_NEW, i[7:0], 24'($urandom())));
        end
        drain();
        set_config(1, 1, 256, 2);

        dir_rows = '{
            '{mk(MODE_LOAD_NEW, 8'd0,   24'h000000), 1'b0, '0},
            '{mk(MODE_LOAD_NEW, 8'd1,   24'hFFFFFF), 1'b0, '0},
            '{mk(MODE_LOAD_OLD, 8'd0,   24'h000000), 1'b0, '0},
            '{mk(MODE_LOAD_OLD, 8'd255, 24'hFFFFFF), 1'b0, '0},
            '{mk(MODE_LOAD_OLD, 8'd1,   24'h808080), 1'b0, '0},
            '{mk(MODE_LOAD_OLD, 8'd2,   24'h7F7F7F), 1'b0, '0},
            '{mk(MODE_PIXEL,    8'd0,   24'h000000), 1'b1, '{8'd0, 1'b1}},
            '{mk(MODE_PIXEL,    8'd255, 24'hFFFFFF), 1'b1, '{8'd1, 1'b1}},
            '{mk(MODE_PIXEL,    8'd1,   24'h000000), 1'b1, '{8'd1, 1'b1}},
            '{mk(MODE_PIXEL,    8'd2,   24'h000000), 1'b1, '{8'd0, 1'b1}},
            '{mk(MODE_NOP,      8'd255, 24'hFFFFFF), 1'b0, '0},
            '{mk(MODE_PIXEL,    8'd255, 24'h000000), 1'b1, '{8'd1, 1'b1}},
            // equal target entries: the lower index must win
            '{mk(MODE_LOAD_NEW, 8'd1,   24'h000000), 1'b0, '0},
            '{mk(MODE_PIXEL,    8'd255, 24'h000000), 1'b1, '{8'd0, 1'b1}},
            '{mk(MODE_LOAD_NEW, 8'd1,   24'hFFFFFF), 1'b0, '0},
            '{mk(MODE_PIXEL,    8'd1,   24'hFFFFFF), 1'b0, '0},
            '{mk(MODE_LOAD_OLD, 8'd3,   24'hFF0080), 1'b0, '0},
            '{mk(MODE_PIXEL,    8'd3,   24'h000000), 1'b0, '0}
        };
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].item);
            // Check typed answers against the shadow.
            if (dir_rows[i].known) begin
                res = remap_queue[$];
                if (res != dir_rows[i].want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("directed row %0d: table says %0d/%0b, shadow says %0d/%0b",
                                 i, dir_rows[i].want.new_index, dir_rows[i].want.last_of_frame,
                                 res.new_index, res.last_of_frame);
                end
            end
        end
        drain();

        // Geometry and palette sizes, including zero and over-range values.
        phases = '{
            '{3,    2,     256, 16,  160, 1'b0},
            '{1,    1,     200, 8,   25,  1'b0},
            '{1024, 1,     256, 4,   40,  1'b0},
            '{0,    0,     0,   1,   15,  1'b0},
            '{2047, 2,     511, 0,   20,  1'b0},
            '{5,    65535, 100, 256, 25,  1'b0},
            '{7,    4,     256, 32,  120, 1'b1},
            '{2,    3,     37,  511, 20,  1'b0},
            '{6,    5,     256, 12,  150, 1'b0}
        };
        foreach (phases[p]) begin
            set_config(phases[p].w, phases[p].h, phases[p].o, phases[p].n);
            no_idle = phases[p].burst;
            for (int k = 0; k < phases[p].cnt; k++) begin
                r = $urandom_range(0, 99);
                if (r < 84)
                    it = mk(MODE_PIXEL, 8'($urandom_range(0, 255)), 24'($urandom()));
                else if (r < 92)
                    it = mk(($urandom_range(0, 1) != 0) ? MODE_LOAD_OLD : MODE_LOAD_NEW,
                            8'($urandom_range(0, 255)), 24'($urandom()));
                else
                    it = mk(MODE_NOP, 8'($urandom_range(0, 255)), 24'($urandom()));
                send_item(it);
            end
            no_idle = 1'b0;
            // Hold the sender until every result is back before reconfiguring.
            drain();
        end

        $display("Covered %0d pixels, %0d palette loads, %0d dropped items, %0d results",
                 pixels_sent, loads_sent, drops_sent, results_seen);
        $display("over %0d geometry settings, %0d completed frames", phases.size() + 1,
                 frames_seen);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: random back-pressure, one long hold-off, checking
    // ------------------------------------------------------------------
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge aclk) begin
        fsd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_data.last_of_frame) frames_seen++;
            if (remap_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d/%0b", m_data.new_index,
                             m_data.last_of_frame);
            end else begin
                want = remap_queue.pop_front();
                if (m_data.new_index !== want.new_index ||
                    m_data.last_of_frame !== want.last_of_frame) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected index %0d last %0b, got %0d last %0b",
                                 results_seen, want.new_index, want.last_of_frame,
                                 m_data.new_index, m_data.last_of_frame);
                end
            end
        end
        // Stall the receiver long enough for the input side to back up.
        if (!hold_done && results_seen == HOLD_AT_RESULT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && (no_idle || $urandom_range(0, 99) >= 33);
        end
    end

    // Watchdog: abort when nothing moves for too long.
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= HANG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
